// ----- rtl/core/sptw_pkg.sv -----
// Shared types and constants of the Sv32 page-table walker.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
package sptw_pkg;

    // Input command codes
    typedef enum logic {
        CMD_TRANSLATE    = 1'b0,
        CMD_PTE_RESPONSE = 1'b1
    } cmd_t;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_READ      = 2'd0,
        KIND_WRITEBACK = 2'd1,
        KIND_DONE      = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSLATE_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_PAGE_NUMBER = 1'b1;
    localparam int CFG_DATA_W = 22;

    // Sv32 field widths and PTE bit positions
    localparam int XLEN     = 32;
    localparam int PPN_W    = 22;
    localparam int VPN_W    = 10;
    localparam int OFFSET_W = 12;
    localparam int PTE_V    = 0;
    localparam int PTE_R    = 1;
    localparam int PTE_X    = 3;
    localparam int PTE_A    = 6;
    localparam int PTE_D    = 7;

    // Result queue sizing
    localparam int RESULT_DEPTH = 4;
    localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
    localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

    typedef struct packed {
        cmd_t              command;
        logic [XLEN-1:0]   vaddr;
        logic              is_store;
        logic [XLEN-1:0]   pte_word;
    } req_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [XLEN-1:0]   mem_address;
        logic [XLEN-1:0]   mem_write_data;
        logic [XLEN-1:0]   paddr;
        logic              page_fault;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              waiting;
        logic              level;
        logic              held_write;
        logic [XLEN-1:0]   held_va;
        logic [XLEN-1:0]   entry_address;
    } walk_state_t;

    // Walk step outcome: how many results and the next walker state
    typedef struct packed {
        logic [1:0]        count;
        result_t           res0;
        result_t           res1;
        walk_state_t       state_next;
    } walk_step_t;

    typedef struct packed {
        logic [RESULT_CNT_W-1:0] count;
    } queue_status_t;

endpackage

// ----- rtl/core/sptw_req_if.sv -----
// Input channel of the walker: translate requests and PTE responses.
// Depends on sptw_pkg.
interface sptw_req_if;
    logic                       valid;
    logic                       ready;
    sptw_pkg::cmd_t             command;
    logic [sptw_pkg::XLEN-1:0]  vaddr;
    logic                       is_store;
    logic [sptw_pkg::XLEN-1:0]  pte_word;

    modport source (output valid, command, vaddr, is_store, pte_word,
                    input ready);
    modport sink   (input valid, command, vaddr, is_store, pte_word,
                    output ready);
endinterface

// ----- rtl/core/sptw_rsp_if.sv -----
// Output channel of the walker: PTE reads, write-backs and finished translations.
// Depends on sptw_pkg.
interface sptw_rsp_if;
    logic                       valid;
    logic                       ready;
    sptw_pkg::kind_t            kind;
    logic [sptw_pkg::XLEN-1:0]  mem_address;
    logic [sptw_pkg::XLEN-1:0]  mem_write_data;
    logic [sptw_pkg::XLEN-1:0]  paddr;
    logic                       page_fault;
    logic                       last;

    modport source (output valid, kind, mem_address, mem_write_data, paddr,
                    page_fault, last, input ready);
    modport sink   (input valid, kind, mem_address, mem_write_data, paddr,
                    page_fault, last, output ready);
endinterface

// ----- rtl/core/sptw_walk_logic.sv -----
// One walk step: decodes a registered beat against the walker state and forms
// up to two results plus the next state. Purely combinational; depends on sptw_pkg.
module sptw_walk_logic (
    input  sptw_pkg::req_item_t                 item,
    input  sptw_pkg::walk_state_t               state,
    input  logic                                translate_enable,
    input  logic [sptw_pkg::PPN_W-1:0]          root_page_number,
    output sptw_pkg::walk_step_t                step
);

    logic [sptw_pkg::VPN_W-1:0]     vpn0;
    logic [sptw_pkg::VPN_W-1:0]     vpn1;
    logic [sptw_pkg::VPN_W-1:0]     ppn0;
    logic [sptw_pkg::XLEN-1:0]      new_pte;
    logic [sptw_pkg::VPN_W-1:0]     page0;
    logic                           is_leaf;
    sptw_pkg::result_t              fault_res;
    sptw_pkg::walk_state_t          idle_state;

    assign vpn0    = state.held_va[21:12];
    assign vpn1    = item.vaddr[31:22];
    assign ppn0    = item.pte_word[19:10];
    assign is_leaf = item.pte_word[sptw_pkg::PTE_R] | item.pte_word[sptw_pkg::PTE_X];
    assign page0   = state.level ? vpn0 : ppn0;

    // Accessed always, dirty on stores
    always_comb
    begin
        new_pte = item.pte_word;
        new_pte[sptw_pkg::PTE_A] = 1'b1;
        if (state.held_write)
        begin
            new_pte[sptw_pkg::PTE_D] = 1'b1;
        end
    end

    // Fault answer and return-to-idle state
    always_comb
    begin
        fault_res = '0;
        fault_res.kind = sptw_pkg::KIND_DONE;
        fault_res.paddr = state.held_va;
        fault_res.page_fault = 1'b1;
        fault_res.last = 1'b1;

        idle_state = state;
        idle_state.waiting = 1'b0;
        idle_state.level = 1'b1;
    end

    // Step decode
    always_comb
    begin
        step = '0;
        step.state_next = state;
        step.res0.kind = sptw_pkg::KIND_READ;
        step.res1.kind = sptw_pkg::KIND_READ;

        if (item.command == sptw_pkg::CMD_TRANSLATE)
        begin
            if (!state.waiting)
            begin
                step.count = 2'd1;
                if (!translate_enable)
                begin
                    // pass-through
                    step.res0.kind = sptw_pkg::KIND_DONE;
                    step.res0.paddr = item.vaddr;
                    step.res0.last = 1'b1;
                end
                else
                begin
                    // root PTE read: root*4096 + vpn1*4, kept to 32 bits
                    step.state_next.waiting = 1'b1;
                    step.state_next.level = 1'b1;
                    step.state_next.held_va = item.vaddr;
                    step.state_next.held_write = item.is_store;
                    step.state_next.entry_address = {root_page_number[19:0], vpn1, 2'b00};
                    step.res0.kind = sptw_pkg::KIND_READ;
                    step.res0.mem_address = {root_page_number[19:0], vpn1, 2'b00};
                    step.res0.last = 1'b1;
                end
            end
        end
        else if (state.waiting)
        begin
            if (!item.pte_word[sptw_pkg::PTE_V])
            begin
                step.count = 2'd1;
                step.res0 = fault_res;
                step.state_next = idle_state;
            end
            else if (!is_leaf)
            begin
                step.count = 2'd1;
                if (!state.level)
                begin
                    step.res0 = fault_res;
                    step.state_next = idle_state;
                end
                else
                begin
                    // descend to level 0
                    step.state_next.level = 1'b0;
                    step.state_next.entry_address = {item.pte_word[29:10], vpn0, 2'b00};
                    step.res0.kind = sptw_pkg::KIND_READ;
                    step.res0.mem_address = {item.pte_word[29:10], vpn0, 2'b00};
                    step.res0.last = 1'b1;
                end
            end
            else if (state.level && (ppn0 != '0))
            begin
                // misaligned superpage
                step.count = 2'd1;
                step.res0 = fault_res;
                step.state_next = idle_state;
            end
            else
            begin
                step.count = 2'd2;
                step.state_next = idle_state;
                step.res0.kind = sptw_pkg::KIND_WRITEBACK;
                step.res0.mem_address = state.entry_address;
                step.res0.mem_write_data = new_pte;
                step.res1.kind = sptw_pkg::KIND_DONE;
                // PPN1 shifted to bit 22; its top two bits fall off at 32 bits
                step.res1.paddr = {item.pte_word[29:20], page0,
                                   state.held_va[sptw_pkg::OFFSET_W-1:0]};
                step.res1.last = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/sptw_result_queue.sv -----
// Small result queue: takes up to two results a cycle, hands out one beat a cycle while out_ch.ready is high.
// Depends on sptw_pkg and sptw_rsp_if.
module sptw_result_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              push_count,
    input  sptw_pkg::result_t       push0,
    input  sptw_pkg::result_t       push1,
    output sptw_pkg::queue_status_t status,
    sptw_rsp_if.source              out_ch
);

    sptw_pkg::result_t                      entry_reg [sptw_pkg::RESULT_DEPTH];
    logic [sptw_pkg::RESULT_PTR_W-1:0]      wr_ptr_reg;
    logic [sptw_pkg::RESULT_PTR_W-1:0]      wr_ptr_next;
    logic [sptw_pkg::RESULT_PTR_W-1:0]      wr_ptr_plus1;
    logic [sptw_pkg::RESULT_PTR_W-1:0]      rd_ptr_reg;
    logic [sptw_pkg::RESULT_CNT_W-1:0]      count_reg;
    logic [sptw_pkg::RESULT_CNT_W-1:0]      count_next;
    logic                                   pop;
    sptw_pkg::result_t                      head;

    assign pop          = out_ch.valid && out_ch.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + sptw_pkg::RESULT_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + sptw_pkg::RESULT_PTR_W'(push_count);
    assign count_next   = count_reg + sptw_pkg::RESULT_CNT_W'(push_count)
                        - sptw_pkg::RESULT_CNT_W'(pop);

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + sptw_pkg::RESULT_PTR_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

    // Head beat
    assign head                  = entry_reg[rd_ptr_reg];
    assign out_ch.valid          = (count_reg != '0);
    assign out_ch.kind           = head.kind;
    assign out_ch.mem_address    = head.mem_address;
    assign out_ch.mem_write_data = head.mem_write_data;
    assign out_ch.paddr          = head.paddr;
    assign out_ch.page_fault     = head.page_fault;
    assign out_ch.last           = head.last;
    assign status.count          = count_reg;

endmodule

// ----- rtl/core/sv32_page_table_walker.sv -----
// Sv32 two-level page-table walker, top level.
// An accepted beat is registered in the input register, walked once the result queue
// has room for two beats, and its results are then queued; a leaf's second result follows its first.
// Throughput: one input beat per cycle while results drain; a leaf puts two beats
// into the result queue, so the output port (one beat a cycle) sets the rate then.
// Reset (rst_n, async low): idle, level 1, translation off, root page 0, queue empty.
module sv32_page_table_walker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [sptw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sptw_pkg::CFG_DATA_W-1:0]     cfg_data,
    sptw_req_if.sink                            request,
    sptw_rsp_if.source                          result
);

    logic                               translate_enable_reg;
    logic [sptw_pkg::PPN_W-1:0]         root_page_number_reg;
    logic                               in_valid_reg;
    sptw_pkg::req_item_t                in_item_reg;
    sptw_pkg::walk_state_t              walk_state_reg;
    sptw_pkg::walk_step_t               step;
    sptw_pkg::queue_status_t            queue_status;
    logic [sptw_pkg::RESULT_CNT_W:0]    room;
    logic                               pop;
    logic                               fire;
    logic                               accept;
    logic [1:0]                         push_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            translate_enable_reg <= 1'b0;
            root_page_number_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                sptw_pkg::CFG_TRANSLATE_ENABLE: translate_enable_reg <= cfg_data[0];
                sptw_pkg::CFG_ROOT_PAGE_NUMBER: root_page_number_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Walk step fires when the queue can take two beats
    assign pop    = result.valid && result.ready;
    assign room   = (sptw_pkg::RESULT_CNT_W+1)'(sptw_pkg::RESULT_DEPTH)
                  - {1'b0, queue_status.count} + (sptw_pkg::RESULT_CNT_W+1)'(pop);
    assign fire   = in_valid_reg && (room >= (sptw_pkg::RESULT_CNT_W+1)'(2));
    assign request.ready = !in_valid_reg || fire;
    assign accept = request.valid && request.ready;
    assign push_count = fire ? step.count : 2'd0;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            in_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.command  <= request.command;
            in_item_reg.vaddr    <= request.vaddr;
            in_item_reg.is_store <= request.is_store;
            in_item_reg.pte_word <= request.pte_word;
        end
    end

    // Walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_state_reg.waiting       <= 1'b0;
            walk_state_reg.level         <= 1'b1;
            walk_state_reg.held_write    <= 1'b0;
            walk_state_reg.held_va       <= '0;
            walk_state_reg.entry_address <= '0;
        end
        else if (fire)
        begin
            walk_state_reg <= step.state_next;
        end
    end

    sptw_walk_logic u_walk (
        .item             (in_item_reg),
        .state            (walk_state_reg),
        .translate_enable (translate_enable_reg),
        .root_page_number (root_page_number_reg),
        .step             (step)
    );

    sptw_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (step.res0),
        .push1      (step.res1),
        .status     (queue_status),
        .out_ch     (result)
    );

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_status.count <= sptw_pkg::RESULT_CNT_W'(sptw_pkg::RESULT_DEPTH))
        else $error("result queue overfilled");

    // A write-back is never the final beat of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == sptw_pkg::KIND_WRITEBACK) |-> !result.last)
        else $error("write-back marked last");

    // A taken write-back is directly followed by its translation
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && result.kind == sptw_pkg::KIND_WRITEBACK)
        |=> (result.valid && result.kind == sptw_pkg::KIND_DONE && !result.page_fault))
        else $error("write-back not followed by translation");

endmodule
